// ----- rtl/rrfl_pkg.sv -----
// ----------------------------------------------------------------------------
// Rename free list package
// Action and status codes, sequencer states and checkpoint store controls.
// ----------------------------------------------------------------------------
`default_nettype none

package rrfl_pkg;

  localparam int unsigned RING_DEPTH = 32;
  localparam int unsigned RING_AW    = 5;
  localparam int unsigned REG_W      = 6;
  localparam int unsigned LEVEL_W    = 6;

  typedef enum logic [2:0] {
    ACT_ALLOC   = 3'd0,
    ACT_SETF    = 3'd1,
    ACT_COMMIT  = 3'd2,
    ACT_FREE    = 3'd3,
    ACT_CKPT    = 3'd4,
    ACT_RESTORE = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_EMPTY    = 3'd1,
    STS_FULL     = 3'd2,
    STS_BADID    = 3'd3,
    STS_OVERFLOW = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SAVE,
    S_LOAD,
    S_RESP
  } state_e;

  typedef struct packed {
    logic map_we;
    logic ring_we;
    logic ptr_we;
  } store_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/register_rename_free_list.sv -----
// ----------------------------------------------------------------------------
// Register rename free list
// Rename maps, FIFO free list, ready bits and checkpoints under a sequencer.
// ----------------------------------------------------------------------------
// Sequence: allocate, set, commit, free and rejected actions pass S_EXEC and S_RESP,
//   with done_o strobed from a register fed by S_RESP; a checkpoint adds S_SAVE and
//   a restore S_LOAD, where the copy counter moves one map and ring entry per cycle.
// Handshake: busy stays high until the result cycle, so a new beat is taken
//   only once the previous one is done. Results are never stalled.
// Reset: maps hold identity, free list holds the spare registers, all ready.
`default_nettype none

module register_rename_free_list import rrfl_pkg::*; #(
  parameter int unsigned ARCH_REGS   = 32,
  parameter int unsigned PHYS_REGS   = 60,
  parameter int unsigned CHECKPOINTS = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] action_i,
  input  wire logic [4:0] arch_reg_i,
  input  wire logic [5:0] phys_reg_i,
  input  wire logic [2:0] checkpoint_id_i,
  output logic            done_o,
  output logic [2:0]      status_o,
  output logic [5:0]      alloc_reg_o,
  output logic [2:0]      new_checkpoint_o,
  output logic [5:0]      free_count_o,
  output logic [5:0]      mapped_phys_o
);

  localparam int unsigned SWEEP = (ARCH_REGS > RING_DEPTH) ? ARCH_REGS : RING_DEPTH;
  localparam int unsigned IW    = $clog2(SWEEP);
  localparam int unsigned CW    = $clog2(SWEEP + 1);
  localparam int unsigned AW    = $clog2(ARCH_REGS);
  localparam int unsigned PW    = $clog2(PHYS_REGS);
  localparam int unsigned SLW   = (CHECKPOINTS > 1) ? $clog2(CHECKPOINTS) : 1;
  localparam int unsigned KW    = $clog2(CHECKPOINTS + 1);
  localparam int unsigned INIT_LEVEL =
    ((PHYS_REGS - ARCH_REGS) < RING_DEPTH) ? (PHYS_REGS - ARCH_REGS) : RING_DEPTH;

  state_e               state_q, state_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [2:0]           action_q;
  logic [4:0]           arch_q;
  logic [5:0]           phys_q;
  logic [2:0]           cid_q;
  logic [SLW-1:0]       slot_q;
  logic [REG_W-1:0]     spec_q   [ARCH_REGS];
  logic [REG_W-1:0]     commit_q [ARCH_REGS];
  logic [REG_W-1:0]     ring_q   [RING_DEPTH];
  logic [RING_AW-1:0]   head_q;
  logic [LEVEL_W-1:0]   level_q;
  logic [PHYS_REGS-1:0] ready_q;
  logic [KW-1:0]        ckcnt_q;
  logic [2:0]           status_q;
  logic [5:0]           alloc_q;
  logic [2:0]           newcp_q;

  logic                 arch_ok, ckpt_full, bad_id, push_in, ring_full;
  logic [AW-1:0]        arch_ix;
  logic [REG_W-1:0]     push_val, alloc_val;
  logic [RING_AW-1:0]   tail;
  logic [CW-1:0]        widx;
  logic [IW-1:0]        idx;
  logic [SLW-1:0]       slot_sel;
  logic [2:0]           status_d;
  store_ctl_t           ctl;
  logic [REG_W-1:0]     map_rd, ring_rd;
  logic [RING_AW-1:0]   head_rd;
  logic [LEVEL_W-1:0]   level_rd;
  logic [PHYS_REGS-1:0] ready_rd;

  assign arch_ok   = int'(arch_q) < ARCH_REGS;
  assign arch_ix   = AW'(arch_q);
  assign ckpt_full = int'(ckcnt_q) >= CHECKPOINTS;
  assign bad_id    = (int'(cid_q) >= int'(ckcnt_q)) || (int'(cid_q) >= CHECKPOINTS);
  assign push_val  = (action_e'(action_q) == ACT_COMMIT) ? commit_q[arch_ix] : phys_q;
  assign push_in   = (int'(push_val) >= ARCH_REGS) && (int'(push_val) < PHYS_REGS);
  assign ring_full = int'(level_q) >= RING_DEPTH;
  assign tail      = head_q + level_q[RING_AW-1:0];
  assign alloc_val = ring_q[head_q];
  assign idx       = cnt_q[IW-1:0];
  assign widx      = cnt_q - CW'(1);
  assign busy      = (state_q != S_IDLE);

  always_comb begin
    status_d = STS_OK;
    case (action_e'(action_q))
      ACT_ALLOC:   if (level_q == '0) status_d = STS_EMPTY;
      ACT_COMMIT:  if (arch_ok && push_in && ring_full) status_d = STS_OVERFLOW;
      ACT_FREE:    if (push_in && ring_full) status_d = STS_OVERFLOW;
      ACT_CKPT:    if (ckpt_full) status_d = STS_FULL;
      ACT_RESTORE: if (bad_id) status_d = STS_BADID;
      default:     status_d = STS_OK;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    ctl      = '0;
    slot_sel = slot_q;
    case (state_q)
      S_IDLE: begin
        if (start) state_d = S_EXEC;
      end
      S_EXEC: begin
        cnt_d   = '0;
        state_d = S_RESP;
        if (action_e'(action_q) == ACT_RESTORE) begin
          slot_sel = SLW'(cid_q);
          if (!bad_id) state_d = S_LOAD;
        end else begin
          slot_sel = SLW'(ckcnt_q);
          if (action_e'(action_q) == ACT_CKPT && !ckpt_full) begin
            ctl.ptr_we = 1'b1;
            state_d    = S_SAVE;
          end
        end
      end
      S_SAVE: begin
        ctl.map_we  = int'(idx) < ARCH_REGS;
        ctl.ring_we = int'(idx) < RING_DEPTH;
        cnt_d       = cnt_q + CW'(1);
        if (int'(cnt_q) == SWEEP - 1) state_d = S_RESP;
      end
      S_LOAD: begin
        cnt_d = cnt_q + CW'(1);
        if (int'(cnt_q) == SWEEP) state_d = S_RESP;
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      action_q <= action_i;
      arch_q   <= arch_reg_i;
      phys_q   <= phys_reg_i;
      cid_q    <= checkpoint_id_i;
    end
    if (state_q == S_EXEC) begin
      slot_q   <= slot_sel;
      status_q <= status_d;
      alloc_q  <= (action_e'(action_q) == ACT_ALLOC && level_q != '0) ? alloc_val : '0;
      newcp_q  <= (action_e'(action_q) == ACT_CKPT && !ckpt_full) ? 3'(ckcnt_q) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ARCH_REGS; i++) begin
        spec_q[i]   <= REG_W'(i);
        commit_q[i] <= REG_W'(i);
      end
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring_q[i] <= (ARCH_REGS + i < PHYS_REGS) ? REG_W'(ARCH_REGS + i) : '0;
      end
      head_q  <= '0;
      level_q <= LEVEL_W'(INIT_LEVEL);
      ready_q <= '1;
      ckcnt_q <= '0;
    end else begin
      case (state_q)
        S_EXEC: begin
          case (action_e'(action_q))
            ACT_ALLOC: begin
              if (level_q != '0) begin
                head_q  <= head_q + RING_AW'(1);
                level_q <= level_q - LEVEL_W'(1);
                if (int'(alloc_val) < PHYS_REGS) ready_q[PW'(alloc_val)] <= 1'b0;
              end
            end
            ACT_SETF: begin
              if (arch_ok) spec_q[arch_ix] <= phys_q;
            end
            ACT_COMMIT, ACT_FREE: begin
              if ((action_e'(action_q) == ACT_FREE || arch_ok) && push_in && !ring_full) begin
                ring_q[tail]           <= push_val;
                level_q                <= level_q + LEVEL_W'(1);
                ready_q[PW'(push_val)] <= 1'b1;
              end
              if (action_e'(action_q) == ACT_COMMIT && arch_ok) commit_q[arch_ix] <= phys_q;
            end
            ACT_CKPT: begin
              if (!ckpt_full) ckcnt_q <= ckcnt_q + KW'(1);
            end
            ACT_RESTORE: begin
              if (!bad_id) begin
                head_q  <= head_rd;
                level_q <= level_rd;
                ready_q <= ready_rd;
              end
            end
            default: ;
          endcase
        end
        S_LOAD: begin
          if (cnt_q != '0) begin
            if (int'(widx) < ARCH_REGS) spec_q[AW'(widx)] <= map_rd;
            if (int'(widx) < RING_DEPTH) ring_q[RING_AW'(widx)] <= ring_rd;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= (state_q == S_RESP);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_RESP) begin
      free_count_o  <= level_q;
      mapped_phys_o <= arch_ok ? spec_q[arch_ix] : '0;
    end
  end

  assign status_o         = status_q;
  assign alloc_reg_o      = alloc_q;
  assign new_checkpoint_o = newcp_q;

  rrfl_ckpt_store #(
    .ARCH_REGS   (ARCH_REGS),
    .PHYS_REGS   (PHYS_REGS),
    .CHECKPOINTS (CHECKPOINTS),
    .SLW         (SLW),
    .IW          (IW)
  ) u_store (
    .clk_i      (clk_i),
    .ctl_i      (ctl),
    .slot_i     (slot_sel),
    .idx_i      (idx),
    .map_wd_i   (spec_q[AW'(idx)]),
    .ring_wd_i  (ring_q[RING_AW'(idx)]),
    .head_wd_i  (head_q),
    .level_wd_i (level_q),
    .ready_wd_i (ready_q),
    .map_rd_o   (map_rd),
    .ring_rd_o  (ring_rd),
    .head_rd_o  (head_rd),
    .level_rd_o (level_rd),
    .ready_rd_o (ready_rd)
  );

endmodule

`default_nettype wire

// ----- rtl/rrfl_ckpt_store.sv -----
// ----------------------------------------------------------------------------
// Rename free list checkpoint store
// Saved maps and rings in memories, saved pointers and ready bits per slot.
// ----------------------------------------------------------------------------
`default_nettype none

module rrfl_ckpt_store import rrfl_pkg::*; #(
  parameter int unsigned ARCH_REGS   = 32,
  parameter int unsigned PHYS_REGS   = 60,
  parameter int unsigned CHECKPOINTS = 8,
  parameter int unsigned SLW = (CHECKPOINTS > 1) ? $clog2(CHECKPOINTS) : 1,
  parameter int unsigned IW  = $clog2((ARCH_REGS > RING_DEPTH) ? ARCH_REGS : RING_DEPTH)
) (
  input  wire logic                 clk_i,
  input  wire store_ctl_t           ctl_i,
  input  wire logic [SLW-1:0]       slot_i,
  input  wire logic [IW-1:0]        idx_i,
  input  wire logic [REG_W-1:0]     map_wd_i,
  input  wire logic [REG_W-1:0]     ring_wd_i,
  input  wire logic [RING_AW-1:0]   head_wd_i,
  input  wire logic [LEVEL_W-1:0]   level_wd_i,
  input  wire logic [PHYS_REGS-1:0] ready_wd_i,
  output logic      [REG_W-1:0]     map_rd_o,
  output logic      [REG_W-1:0]     ring_rd_o,
  output logic      [RING_AW-1:0]   head_rd_o,
  output logic      [LEVEL_W-1:0]   level_rd_o,
  output logic      [PHYS_REGS-1:0] ready_rd_o
);

  localparam int unsigned MAP_DEPTH  = CHECKPOINTS * ARCH_REGS;
  localparam int unsigned RINGS      = CHECKPOINTS * RING_DEPTH;
  localparam int unsigned MAW        = $clog2(MAP_DEPTH);
  localparam int unsigned RAW        = $clog2(RINGS);

  logic [REG_W-1:0]     map_mem  [MAP_DEPTH];
  logic [REG_W-1:0]     ring_mem [RINGS];
  logic [RING_AW-1:0]   head_q   [CHECKPOINTS];
  logic [LEVEL_W-1:0]   level_q  [CHECKPOINTS];
  logic [PHYS_REGS-1:0] ready_q  [CHECKPOINTS];
  logic [MAW-1:0]       map_addr;
  logic [RAW-1:0]       ring_addr;

  assign map_addr  = MAW'(int'(slot_i) * ARCH_REGS + int'(idx_i));
  assign ring_addr = RAW'(int'(slot_i) * RING_DEPTH + int'(idx_i));

  always_ff @(posedge clk_i) begin
    if (ctl_i.map_we) begin
      map_mem[map_addr] <= map_wd_i;
    end
    if (ctl_i.ring_we) begin
      ring_mem[ring_addr] <= ring_wd_i;
    end
    map_rd_o  <= map_mem[map_addr];
    ring_rd_o <= ring_mem[ring_addr];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ptr_we) begin
      head_q[slot_i]  <= head_wd_i;
      level_q[slot_i] <= level_wd_i;
      ready_q[slot_i] <= ready_wd_i;
    end
  end

  assign head_rd_o  = head_q[slot_i];
  assign level_rd_o = level_q[slot_i];
  assign ready_rd_o = ready_q[slot_i];

endmodule

`default_nettype wire

// ----- rtl/rrfl_checker.sv -----
// ----------------------------------------------------------------------------
// Rename free list checker
// Port-level checks on the command handshake and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

module rrfl_checker import rrfl_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       done_o,
  input wire logic [2:0] status_o,
  input wire logic [5:0] alloc_reg_o,
  input wire logic [5:0] free_count_o
);

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("busy not raised after accepted beat");

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result beat while busy");

  a_done_pulse : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result beat longer than one cycle");

  a_fail_alloc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != STS_OK |-> alloc_reg_o == 6'd0)
    else $error("allocated register on failed beat");

  a_level : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> free_count_o <= 6'(RING_DEPTH)) else $error("free count beyond ring depth");

endmodule

bind register_rename_free_list rrfl_checker u_rrfl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .status_o     (status_o),
  .alloc_reg_o  (alloc_reg_o),
  .free_count_o (free_count_o)
);

`default_nettype wire
